// ----- hw/rtl/ftfp_pkg.sv -----
package ftfp_pkg;

	localparam int FRAME_BYTES_DEF = 64;
	localparam int HDR_BYTES       = 3;
	localparam int META_HDR_BYTES  = 7;
	localparam int COUNT_W         = 22;
	localparam int IDX_W_MAX       = 8;
	localparam int CMD_DEPTH       = 2;
	localparam int OUT_DEPTH       = 4;

	// frame types carried in the low two header bits
	localparam logic [1:0] TYPE_META = 2'd0;
	localparam logic [1:0] TYPE_FULL = 2'd1;
	localparam logic [1:0] TYPE_PART = 2'd2;

	// commands from the front end to the frame engine
	localparam logic [2:0] OP_NAME  = 3'd0;
	localparam logic [2:0] OP_CHUNK = 3'd1;
	localparam logic [2:0] OP_FULL  = 3'd2;
	localparam logic [2:0] OP_PART  = 3'd3;
	localparam logic [2:0] OP_META  = 3'd4;

	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_last;
	} out_item_t;

	typedef struct packed {
		logic [2:0]           op;
		logic [IDX_W_MAX-1:0] idx;   // store index, or name length for OP_META
		logic [7:0]           data;
		logic [COUNT_W-1:0]   count;
		logic [31:0]          size;
	} cmd_t;

endpackage

// ----- hw/rtl/ftfp_fifo.sv -----
module ftfp_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [W-1:0]                 wr_data,
	input  logic                         rd_en,
	output logic [W-1:0]                 rd_data,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd, full;

	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign count   = count_q;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/ftfp_front.sv -----
module ftfp_front import ftfp_pkg::*; #(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  in_item_t in_data,
	input  logic [31:0] size_limit,
	output logic     cmd_push,
	output cmd_t     cmd
);

	localparam int CHUNK_BYTES = FRAME_BYTES - HDR_BYTES;
	localparam int NAME_BYTES  = FRAME_BYTES - META_HDR_BYTES;
	localparam int CF_W        = $clog2(CHUNK_BYTES + 1);
	localparam int NF_W        = $clog2(NAME_BYTES + 1);

	logic [CF_W-1:0]    chunk_fill_q, chunk_fill_d, fill_base, fill_inc;
	logic [NF_W-1:0]    name_fill_q, name_fill_d;
	logic [31:0]        bytes_taken_q, bytes_taken_d, taken_inc;
	logic [COUNT_W-1:0] msg_count_q, msg_count_d;

	assign fill_base = (chunk_fill_q >= CF_W'(CHUNK_BYTES)) ? '0 : chunk_fill_q;
	assign fill_inc  = fill_base + 1'b1;
	assign taken_inc = bytes_taken_q + 32'd1;

	always_comb begin
		cmd_push      = 1'b0;
		cmd           = '0;
		cmd.data      = in_data.data_byte;
		cmd.count     = msg_count_q;
		cmd.size      = size_limit;
		chunk_fill_d  = chunk_fill_q;
		name_fill_d   = name_fill_q;
		bytes_taken_d = bytes_taken_q;
		msg_count_d   = msg_count_q;
		if (in_valid) begin
			if (!in_data.req_type) begin
				if (in_data.data_byte != 8'd0) begin
					// name bytes past the frame's room are dropped
					if (name_fill_q < NF_W'(NAME_BYTES)) begin
						cmd_push    = 1'b1;
						cmd.op      = OP_NAME;
						cmd.idx     = IDX_W_MAX'(name_fill_q);
						name_fill_d = name_fill_q + 1'b1;
					end
				end else begin
					cmd_push      = 1'b1;
					cmd.op        = OP_META;
					cmd.idx       = IDX_W_MAX'(name_fill_q);
					cmd.count     = '0;   // metadata frame always carries counter 0
					name_fill_d   = '0;
					chunk_fill_d  = '0;
					bytes_taken_d = '0;
					msg_count_d   = COUNT_W'(1);
				end
			end else if (bytes_taken_q < size_limit) begin
				cmd_push      = 1'b1;
				cmd.idx       = IDX_W_MAX'(fill_base);
				bytes_taken_d = taken_inc;
				if (fill_inc == CF_W'(CHUNK_BYTES)) begin
					cmd.op       = OP_FULL;
					chunk_fill_d = '0;
					msg_count_d  = msg_count_q + 1'b1;
				end else if (taken_inc == size_limit) begin
					cmd.op       = OP_PART;
					chunk_fill_d = '0;
					msg_count_d  = msg_count_q + 1'b1;
				end else begin
					cmd.op       = OP_CHUNK;
					chunk_fill_d = fill_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_fill_q  <= '0;
			name_fill_q   <= '0;
			bytes_taken_q <= '0;
			msg_count_q   <= COUNT_W'(1);
		end else begin
			chunk_fill_q  <= chunk_fill_d;
			name_fill_q   <= name_fill_d;
			bytes_taken_q <= bytes_taken_d;
			msg_count_q   <= msg_count_d;
		end
	end

endmodule

// ----- hw/rtl/ftfp_back.sv -----
module ftfp_back import ftfp_pkg::*; #(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  logic      cmd_empty,
	output logic      cmd_pop,
	output logic      empty,
	input  logic      pop,
	output out_item_t out_data
);

	localparam int CHUNK_BYTES = FRAME_BYTES - HDR_BYTES;
	localparam int NAME_BYTES  = FRAME_BYTES - META_HDR_BYTES;
	localparam int CA_W        = $clog2(CHUNK_BYTES);
	localparam int NA_W        = $clog2(NAME_BYTES);
	localparam int POS_W       = $clog2(FRAME_BYTES);
	localparam int OC_W        = $clog2(OUT_DEPTH + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	localparam logic [1:0] SRC_CONST = 2'd0;
	localparam logic [1:0] SRC_CHUNK = 2'd1;
	localparam logic [1:0] SRC_NAME  = 2'd2;

	logic [7:0] chunk_mem [CHUNK_BYTES];
	logic [7:0] name_mem  [NAME_BYTES];

	logic                 state_q;
	logic [POS_W-1:0]     pos_q;
	logic [1:0]           ftype_q;
	logic [COUNT_W-1:0]   count_q;
	logic [31:0]          size_q;
	logic [IDX_W_MAX-1:0] len_q;

	logic                 v_s1;
	logic [1:0]           src_s1;
	logic [7:0]           const_s1;
	logic                 last_s1;
	logic [7:0]           chunk_rd_q, name_rd_q;

	logic                 ob_push;
	logic [OC_W-1:0]      ob_count;
	out_item_t            ob_data;

	logic                 room, issue;
	logic [8:0]           p9, rel3, rel4, rel7, len9;
	logic [23:0]          hdr;
	logic [1:0]           src_d;
	logic [7:0]           const_d;
	logic [CA_W-1:0]      chunk_raddr;
	logic [NA_W-1:0]      name_raddr;
	logic                 chunk_we, name_we;

	assign cmd_pop  = (state_q == ST_IDLE) && !cmd_empty;
	assign chunk_we = cmd_pop && (cmd.op inside {OP_CHUNK, OP_FULL, OP_PART});
	assign name_we  = cmd_pop && (cmd.op == OP_NAME);

	// one byte in flight between issue and the output queue
	assign room  = ({1'b0, ob_count} + (OC_W+1)'(v_s1)) < (OC_W+1)'(OUT_DEPTH);
	assign issue = (state_q == ST_EMIT) && room;

	assign p9   = 9'(pos_q);
	assign rel3 = p9 - 9'd3;
	assign rel4 = p9 - 9'd4;
	assign rel7 = p9 - 9'd7;
	assign len9 = 9'(len_q);
	assign hdr  = {count_q, ftype_q};

	always_comb begin
		src_d       = SRC_CONST;
		const_d     = 8'd0;
		chunk_raddr = rel3[CA_W-1:0];
		name_raddr  = rel7[NA_W-1:0];
		if (p9 < 9'(HDR_BYTES)) begin
			case (pos_q[1:0])
				2'd0:    const_d = hdr[7:0];
				2'd1:    const_d = hdr[15:8];
				default: const_d = hdr[23:16];
			endcase
		end else begin
			case (ftype_q)
				TYPE_META: begin
					if (p9 < 9'(META_HDR_BYTES)) begin
						case (rel3[1:0])
							2'd0:    const_d = size_q[7:0];
							2'd1:    const_d = size_q[15:8];
							2'd2:    const_d = size_q[23:16];
							default: const_d = size_q[31:24];
						endcase
					end else if (rel7 < len9) begin
						src_d = SRC_NAME;
					end
				end
				TYPE_FULL: begin
					src_d = SRC_CHUNK;
				end
				default: begin
					chunk_raddr = rel4[CA_W-1:0];
					if (p9 == 9'(HDR_BYTES)) begin
						const_d = len_q;
					end else if (rel4 < len9) begin
						src_d = SRC_CHUNK;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (chunk_we) begin
			chunk_mem[cmd.idx[CA_W-1:0]] <= cmd.data;
		end
		chunk_rd_q <= chunk_mem[chunk_raddr];
	end

	always_ff @(posedge clk) begin
		if (name_we) begin
			name_mem[cmd.idx[NA_W-1:0]] <= cmd.data;
		end
		name_rd_q <= name_mem[name_raddr];
	end

	always_ff @(posedge clk) begin
		src_s1   <= src_d;
		const_s1 <= const_d;
		last_s1  <= (pos_q == POS_W'(FRAME_BYTES-1));
		if (cmd_pop) begin
			count_q <= cmd.count;
			size_q  <= cmd.size;
			case (cmd.op)
				OP_META: begin
					ftype_q <= TYPE_META;
					len_q   <= cmd.idx;
				end
				OP_FULL: begin
					ftype_q <= TYPE_FULL;
					len_q   <= cmd.idx + 1'b1;
				end
				default: begin
					ftype_q <= TYPE_PART;
					len_q   <= cmd.idx + 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					pos_q <= '0;
					if (cmd_pop && (cmd.op inside {OP_FULL, OP_PART, OP_META})) begin
						state_q <= ST_EMIT;
					end
				end
				default: begin
					if (issue) begin
						pos_q <= pos_q + 1'b1;
						if (pos_q == POS_W'(FRAME_BYTES-1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
			endcase
		end
	end

	always_comb begin
		ob_data.frame_last = last_s1;
		case (src_s1)
			SRC_CHUNK: ob_data.frame_byte = chunk_rd_q;
			SRC_NAME:  ob_data.frame_byte = name_rd_q;
			default:   ob_data.frame_byte = const_s1;
		endcase
	end

	// issue leaves a slot for the beat in flight, so the push never meets a full queue
	assign ob_push = v_s1;

	ftfp_fifo #(
		.W     ($bits(out_item_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ob_push),
		.wr_data (ob_data),
		.rd_en   (pop),
		.rd_data (out_data),
		.empty   (empty),
		.count   (ob_count)
	);

endmodule

// ----- hw/rtl/file_transfer_frame_packer.sv -----
// A frame's first beat passes the command queue, the frame engine's state register and its
// issue register on its way to the result queue. Throughput: one input beat per cycle while
// the 2-deep command queue has room. The frame engine pops one command at a time and takes
// none while it sends a frame; the rate is bounded by the frame engine and result stalls.
// Reset (arst_n low, asynchronous): queues empty, counters cleared, message counter 1,
// size limit 0. The byte stores are not cleared and need no clearing pass.
module file_transfer_frame_packer import ftfp_pkg::*; #(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input beats
	input  logic        push,
	output logic        full,
	input  in_item_t    in_data,
	// result beats
	output logic        empty,
	input  logic        pop,
	output out_item_t   out_data,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CQ_W = $clog2(CMD_DEPTH + 1);

	// Register map: size limit at byte addresses 0 to 3; addresses 4 to 7 read zero and ignore writes.
	logic [31:0] size_limit_q;
	logic        reg_wr;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? size_limit_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_limit_q <= 32'd0;
		end else if (reg_wr) begin
			size_limit_q <= pwdata;
		end
	end

	// Front end: counts name and content bytes, drops what falls outside the file, and turns
	// each kept beat into one command (store, store and send a frame, or send the metadata frame).
	logic            in_valid;
	logic            cmd_push, cmd_full, cmd_empty, cmd_pop;
	logic [CQ_W-1:0] cmd_count;
	cmd_t            cmd_wr, cmd_rd;

	assign in_valid = push && !full;
	assign cmd_full = (cmd_count == CQ_W'(CMD_DEPTH));
	assign full     = cmd_full;

	ftfp_front #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_data    (in_data),
		.size_limit (size_limit_q),
		.cmd_push   (cmd_push),
		.cmd        (cmd_wr)
	);

	// Command queue: lets the front keep taking beats while a frame is serialised.
	ftfp_fifo #(
		.W     ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_wr),
		.rd_en   (cmd_pop),
		.rd_data (cmd_rd),
		.empty   (cmd_empty),
		.count   (cmd_count)
	);

	// Frame engine: owns the chunk and name stores, writes them in command order and
	// walks a frame one byte a cycle, while its result queue has room, into its own result queue.
	ftfp_back #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_rd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.out_data  (out_data)
	);

endmodule
